@@ src/wsd_pkg.sv @@
package wsd_pkg;

    localparam int unsigned LEN_CODE_16 = 126;
    localparam int unsigned LEN_CODE_64 = 127;
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER     = 2'd0,
        KIND_PAYLOAD    = 2'd1,
        KIND_INCOMPLETE = 2'd2
    } kind_t;

    // One classified beat passed from the parser to the output stage.
    typedef struct packed {
        kind_t       kind;
        logic        fin;
        logic [3:0]  opcode;
        logic        masked;
        logic [63:0] length;
        logic [31:0] key;
        logic [3:0]  hlen;
        logic [7:0]  raw;
        logic [1:0]  kpos;
        logic        last;
    } wsd_token_t;

    // Extended length bytes that follow a given 7-bit length code.
    function automatic logic [3:0] ext_bytes(input logic [6:0] code);
        logic [3:0] n;
        begin
            if (code == 7'(LEN_CODE_16))
            begin
                n = 4'd2;
            end
            else if (code == 7'(LEN_CODE_64))
            begin
                n = 4'd8;
            end
            else
            begin
                n = 4'd0;
            end
            return n;
        end
    endfunction

endpackage

@@ src/wsd_if.sv @@
interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface wsd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic        final_fragment;
    logic [3:0]  frame_opcode;
    logic        is_masked;
    logic [63:0] payload_length;
    logic [31:0] masking_key;
    logic [3:0]  header_length;
    logic [7:0]  payload_byte;
    logic        last_of_frame;

    modport source (output valid, output result_kind, output final_fragment,
                    output frame_opcode, output is_masked, output payload_length,
                    output masking_key, output header_length, output payload_byte,
                    output last_of_frame, input ready);
    modport sink   (input valid, input result_kind, input final_fragment,
                    input frame_opcode, input is_masked, input payload_length,
                    input masking_key, input header_length, input payload_byte,
                    input last_of_frame, output ready);
endinterface

@@ src/websocket_frame_deframer_core.sv @@
// Channel   Role   Beat contents
// bytes     sink   data_byte, end_of_buffer: one received stream byte
// results   source result_kind and header fields, payload_byte, last_of_frame
//
// One byte is taken per clock; each result passes through a queue slot and then the output register.
// The parser keeps up as long as the two-entry queue is not full, and the
// output register frees a queue slot each cycle the downstream takes a beat.
// The 64-bit payload countdown in the parser sets the per-byte timing path.
// Reset is asynchronous and returns the parser to idle and empties the queue.
module websocket_frame_deframer_core (
    input  logic      clk,
    input  logic      rst_n,
    wsd_in_if.sink    bytes,
    wsd_out_if.source results
);
    import wsd_pkg::*;

    // Front: header parsing and per-byte classification.
    wsd_token_t front_tok;
    logic       front_valid;
    logic       q_not_full;

    // Queue output towards the back end.
    wsd_token_t q_tok;
    logic       q_not_empty;
    logic       q_pop;

    wsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (bytes),
        .tok       (front_tok),
        .tok_valid (front_valid),
        .tok_ready (q_not_full)
    );

    // Decouples parsing from downstream stalls; bytes that make no
    // result never enter it.
    wsd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_tok  (front_tok),
        .push      (front_valid),
        .not_full  (q_not_full),
        .pop_tok   (q_tok),
        .not_empty (q_not_empty),
        .pop       (q_pop)
    );

    // Back: unmasks payload bytes and holds the result beat for the sink.
    wsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (q_tok),
        .tok_valid (q_not_empty),
        .tok_take  (q_pop),
        .results   (results)
    );

endmodule

@@ src/wsd_front.sv @@
module wsd_front (
    input  logic                clk,
    input  logic                rst_n,
    wsd_in_if.sink              bytes,
    output wsd_pkg::wsd_token_t tok,
    output logic                tok_valid,
    input  logic                tok_ready
);
    import wsd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  count_reg, count_next;
    logic        fin_reg, fin_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        mask_reg, mask_next;
    logic [6:0]  lcode_reg, lcode_next;
    logic [63:0] alen_reg, alen_next;
    logic [31:0] key_reg, key_next;
    logic [63:0] remain_reg, remain_next;
    logic [1:0]  kpos_reg, kpos_next;

    logic        fire;
    logic [63:0] rem_dec;
    logic [63:0] len;
    logic [3:0]  needed;

    assign bytes.ready = tok_ready;
    assign fire        = bytes.valid && tok_ready;
    assign rem_dec     = remain_reg - 64'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            count_reg  <= '0;
            fin_reg    <= 1'b0;
            opcode_reg <= '0;
            mask_reg   <= 1'b0;
            lcode_reg  <= '0;
            alen_reg   <= '0;
            key_reg    <= '0;
            remain_reg <= '0;
            kpos_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            fin_reg    <= fin_next;
            opcode_reg <= opcode_next;
            mask_reg   <= mask_next;
            lcode_reg  <= lcode_next;
            alen_reg   <= alen_next;
            key_reg    <= key_next;
            remain_reg <= remain_next;
            kpos_reg   <= kpos_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        fin_next    = fin_reg;
        opcode_next = opcode_reg;
        mask_next   = mask_reg;
        lcode_next  = lcode_reg;
        alen_next   = alen_reg;
        key_next    = key_reg;
        remain_next = remain_reg;
        kpos_next   = kpos_reg;
        tok         = '0;
        tok_valid   = 1'b0;
        len         = '0;
        needed      = '0;

        case (phase_reg)
            PH_PAYLOAD:
            begin
                tok_valid  = fire;
                tok.kind   = KIND_PAYLOAD;
                tok.fin    = fin_reg;
                tok.opcode = opcode_reg;
                tok.masked = mask_reg;
                tok.length = (lcode_reg < 7'(LEN_CODE_16)) ? {57'd0, lcode_reg} : alen_reg;
                tok.key    = key_reg;
                tok.hlen   = count_reg;
                tok.raw    = bytes.data_byte;
                tok.kpos   = kpos_reg;
                tok.last   = (rem_dec == 64'd0);
                remain_next = rem_dec;
                kpos_next   = kpos_reg + 2'd1;
                if (rem_dec == 64'd0)
                begin
                    phase_next  = PH_IDLE;
                    count_next  = '0;
                    fin_next    = 1'b0;
                    opcode_next = '0;
                    mask_next   = 1'b0;
                    lcode_next  = '0;
                    alen_next   = '0;
                    key_next    = '0;
                    remain_next = '0;
                    kpos_next   = '0;
                end
            end
            PH_HEADER:
            begin
                if (count_reg <= 4'd1)
                begin
                    mask_next  = bytes.data_byte[7];
                    lcode_next = bytes.data_byte[6:0];
                end
                else if (count_reg < 4'd2 + ext_bytes(lcode_reg))
                begin
                    alen_next = {alen_reg[55:0], bytes.data_byte};
                end
                else
                begin
                    key_next = {key_reg[23:0], bytes.data_byte};
                end
                count_next = count_reg + 4'd1;
                needed = 4'd2 + ext_bytes(lcode_next) + (mask_next ? 4'd4 : 4'd0);
                len = (lcode_next < 7'(LEN_CODE_16)) ? {57'd0, lcode_next} : alen_next;

                if (count_next >= 4'd2 && count_next == needed)
                begin
                    tok_valid  = fire;
                    tok.kind   = KIND_HEADER;
                    tok.fin    = fin_next;
                    tok.opcode = opcode_next;
                    tok.masked = mask_next;
                    tok.length = len;
                    tok.key    = key_next;
                    tok.hlen   = count_next;
                    tok.last   = (len == 64'd0);
                    if (len == 64'd0)
                    begin
                        phase_next  = PH_IDLE;
                        count_next  = '0;
                        fin_next    = 1'b0;
                        opcode_next = '0;
                        mask_next   = 1'b0;
                        lcode_next  = '0;
                        alen_next   = '0;
                        key_next    = '0;
                        remain_next = '0;
                        kpos_next   = '0;
                    end
                    else
                    begin
                        remain_next = len;
                        kpos_next   = '0;
                        phase_next  = PH_PAYLOAD;
                    end
                end
                else if (bytes.end_of_buffer)
                begin
                    tok_valid   = fire;
                    tok.kind    = KIND_INCOMPLETE;
                    phase_next  = PH_IDLE;
                    count_next  = '0;
                    fin_next    = 1'b0;
                    opcode_next = '0;
                    mask_next   = 1'b0;
                    lcode_next  = '0;
                    alen_next   = '0;
                    key_next    = '0;
                    remain_next = '0;
                    kpos_next   = '0;
                end
            end
            default:
            begin
                // Idle and the unused phase code both start a new frame here.
                phase_next  = PH_HEADER;
                count_next  = 4'd1;
                fin_next    = bytes.data_byte[7];
                opcode_next = bytes.data_byte[3:0];
                mask_next   = 1'b0;
                lcode_next  = '0;
                alen_next   = '0;
                key_next    = '0;
                remain_next = '0;
                kpos_next   = '0;
                if (bytes.end_of_buffer)
                begin
                    tok_valid   = fire;
                    tok.kind    = KIND_INCOMPLETE;
                    phase_next  = PH_IDLE;
                    count_next  = '0;
                    fin_next    = 1'b0;
                    opcode_next = '0;
                end
            end
        endcase
    end

endmodule

@@ src/wsd_queue.sv @@
module wsd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  wsd_pkg::wsd_token_t push_tok,
    input  logic                push,
    output logic                not_full,
    output wsd_pkg::wsd_token_t pop_tok,
    output logic                not_empty,
    input  logic                pop
);
    import wsd_pkg::*;

    localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    wsd_token_t           slot_reg [QUEUE_DEPTH];
    logic [PtrW-1:0]      wr_ptr_reg;
    logic [PtrW-1:0]      rd_ptr_reg;
    logic [PtrW:0]        fill_reg;

    assign not_full  = (fill_reg != (PtrW+1)'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign pop_tok   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

@@ src/wsd_back.sv @@
module wsd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  wsd_pkg::wsd_token_t tok,
    input  logic                tok_valid,
    output logic                tok_take,
    wsd_out_if.source           results
);
    import wsd_pkg::*;

    logic       valid_reg;
    logic [7:0] key_byte;
    logic       load;

    assign load     = tok_valid && (!valid_reg || results.ready);
    assign tok_take = load;

    always_comb
    begin
        case (tok.kpos)
            2'd0:    key_byte = tok.key[31:24];
            2'd1:    key_byte = tok.key[23:16];
            2'd2:    key_byte = tok.key[15:8];
            default: key_byte = tok.key[7:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            results.result_kind    <= tok.kind;
            results.final_fragment <= tok.fin;
            results.frame_opcode   <= tok.opcode;
            results.is_masked      <= tok.masked;
            results.payload_length <= tok.length;
            results.masking_key    <= tok.key;
            results.header_length  <= tok.hlen;
            results.payload_byte   <= (tok.kind == KIND_PAYLOAD) ? (tok.raw ^ key_byte) : tok.raw;
            results.last_of_frame  <= tok.last;
        end
    end

    assign results.valid = valid_reg;

endmodule

@@ tb/sv/tb.sv @@
module tb;
    import wsd_pkg::*;

    // The run is stopped here if the stream ever stalls for good.
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_LIMIT = 10;

    // One expected or observed result beat, at the widths of the result channel.
    typedef struct packed {
        kind_t       kind;
        logic        fin;
        logic [3:0]  opcode;
        logic        masked;
        logic [63:0] length;
        logic [31:0] key;
        logic [3:0]  hlen;
        logic [7:0]  pbyte;
        logic        last;
    } deframe_result_t;

    logic clk;
    logic rst_n;

    wsd_in_if  byte_ch ();
    wsd_out_if result_ch ();

    websocket_frame_deframer_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (byte_ch),
        .results (result_ch)
    );

    // Percent chances that the byte sender inserts an idle cycle and that the
    // result receiver holds ready low. Each test sets its own mix.
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;

    int unsigned bytes_sent;
    int unsigned failures;
    int unsigned cycle_count;

    // Results that the predictor has worked out and the block still owes.
    deframe_result_t expected_results[$];

    // Predictor state: a private copy of everything the parser remembers
    // between bytes.
    phase_t      rx_phase;
    logic [3:0]  rx_hcount;
    logic        rx_fin;
    logic [3:0]  rx_opcode;
    logic        rx_masked;
    logic [6:0]  rx_code;
    logic [63:0] rx_extlen;
    logic [31:0] rx_key;
    logic [63:0] rx_remaining;
    logic [1:0]  rx_kpos;

    always #5 clk = ~clk;

    // A free-running watchdog. Nothing else ends the run on a hang.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Frame parser prediction
    // ------------------------------------------------------------------

    function automatic void clear_frame_state();
        rx_phase     = PH_IDLE;
        rx_hcount    = 4'd0;
        rx_fin       = 1'b0;
        rx_opcode    = 4'd0;
        rx_masked    = 1'b0;
        rx_code      = 7'd0;
        rx_extlen    = 64'd0;
        rx_key       = 32'd0;
        rx_remaining = 64'd0;
        rx_kpos      = 2'd0;
    endfunction

    // Extended length bytes that follow the current 7-bit length code.
    function automatic int ext_len_bytes();
        if (rx_code == 7'(LEN_CODE_16))
        begin
            return 2;
        end
        if (rx_code == 7'(LEN_CODE_64))
        begin
            return 8;
        end
        return 0;
    endfunction

    // Small codes are the length themselves; the two escape codes defer to
    // the extended length that was assembled big-endian.
    function automatic logic [63:0] frame_len();
        if (rx_code < 7'(LEN_CODE_16))
        begin
            return {57'd0, rx_code};
        end
        return rx_extlen;
    endfunction

    function automatic deframe_result_t frame_result(kind_t k, logic [7:0] pb, logic l);
        deframe_result_t r;
        r.kind   = k;
        r.fin    = rx_fin;
        r.opcode = rx_opcode;
        r.masked = rx_masked;
        r.length = frame_len();
        r.key    = rx_key;
        r.hlen   = rx_hcount;
        r.pbyte  = pb;
        r.last   = l;
        return r;
    endfunction

    // Advances the predicted parser by one received byte. Returns 1 and fills
    // r when the byte produces a result beat.
    function automatic bit deframe_byte(input logic [7:0] b, input logic eob,
                                        output deframe_result_t r);
        logic [7:0] key_byte;
        logic [63:0] len;
        int need;
        r = '0;
        if (rx_phase == PH_PAYLOAD)
        begin
            // Key bytes are applied in arrival order, most significant first.
            key_byte = rx_key[8 * (3 - int'(rx_kpos)) +: 8];
            rx_remaining = rx_remaining - 64'd1;
            r = frame_result(KIND_PAYLOAD, b ^ key_byte, rx_remaining == 64'd0);
            rx_kpos = rx_kpos + 2'd1;
            if (r.last)
            begin
                clear_frame_state();
            end
            return 1'b1;
        end
        if (rx_phase != PH_HEADER)
        begin
            clear_frame_state();
            rx_fin    = b[7];
            rx_opcode = b[3:0];
            rx_hcount = 4'd1;
            rx_phase  = PH_HEADER;
        end
        else
        begin
            if (rx_hcount <= 4'd1)
            begin
                rx_masked = b[7];
                rx_code   = b[6:0];
            end
            else if (int'(rx_hcount) < 2 + ext_len_bytes())
            begin
                rx_extlen = {rx_extlen[55:0], b};
            end
            else
            begin
                rx_key = {rx_key[23:0], b};
            end
            rx_hcount = rx_hcount + 4'd1;
            need = 2 + ext_len_bytes() + (rx_masked ? 4 : 0);
            if (rx_hcount >= 4'd2 && int'(rx_hcount) == need)
            begin
                len = frame_len();
                r = frame_result(KIND_HEADER, 8'h00, len == 64'd0);
                if (len == 64'd0)
                begin
                    clear_frame_state();
                end
                else
                begin
                    rx_remaining = len;
                    rx_kpos      = 2'd0;
                    rx_phase     = PH_PAYLOAD;
                end
                return 1'b1;
            end
        end
        // The buffer ran dry before the header was complete.
        if (eob)
        begin
            r = '0;
            r.kind = KIND_INCOMPLETE;
            clear_frame_state();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic string show_result(deframe_result_t r);
        return $sformatf(
            "kind %0d fin %0b op %0h mask %0b len %0h key %0h hlen %0d byte %0h last %0b",
            r.kind, r.fin, r.opcode, r.masked, r.length, r.key, r.hlen,
            r.pbyte, r.last);
    endfunction

    task automatic check_result_beat();
        deframe_result_t got;
        deframe_result_t want;
        logic bad;
        got.kind   = kind_t'(result_ch.result_kind);
        got.fin    = result_ch.final_fragment;
        got.opcode = result_ch.frame_opcode;
        got.masked = result_ch.is_masked;
        got.length = result_ch.payload_length;
        got.key    = result_ch.masking_key;
        got.hlen   = result_ch.header_length;
        got.pbyte  = result_ch.payload_byte;
        got.last   = result_ch.last_of_frame;
        if (expected_results.size() == 0)
        begin
            if (failures < REPORT_LIMIT)
            begin
                $display("cycle %0d: result beat with none expected: %s",
                         cycle_count, show_result(got));
            end
            failures++;
        end
        else
        begin
            want = expected_results.pop_front();
            bad = (got.kind !== want.kind) || (got.fin !== want.fin)
                || (got.opcode !== want.opcode) || (got.masked !== want.masked)
                || (got.length !== want.length) || (got.key !== want.key)
                || (got.hlen !== want.hlen) || (got.pbyte !== want.pbyte)
                || (got.last !== want.last);
            if (bad)
            begin
                if (failures < REPORT_LIMIT)
                begin
                    $display("cycle %0d: result mismatch", cycle_count);
                    $display("  expected %s", show_result(want));
                    $display("  actual   %s", show_result(got));
                end
                failures++;
            end
        end
    endtask

    // The receiver samples the handshake as it stood before the edge, then
    // decides whether to stall for the next cycle.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                check_result_beat();
            end
            result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Sends one byte beat. It is entered and left at a rising edge; valid is
    // left high after the beat is taken so that back-to-back beats never
    // lower and raise it in the same step.
    task automatic send_byte(input logic [7:0] b, input logic eob);
        deframe_result_t r;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < sender_idle_pct);
        end
        byte_ch.valid         <= 1'b1;
        byte_ch.data_byte     <= b;
        byte_ch.end_of_buffer <= eob;
        @(posedge clk);
        while (!byte_ch.ready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
        if (deframe_byte(b, eob, r))
        begin
            expected_results.push_back(r);
        end
    endtask

    // Builds one frame with a random first byte, random mask and key, and a
    // length that is mostly short. About one frame in ten is cut off inside
    // its header by an end of buffer; a few others carry stray end-of-buffer
    // marks on the last header byte and on payload bytes.
    task automatic send_random_frame();
        logic [7:0]  hdr[$];
        logic [63:0] len;
        logic [6:0]  code;
        logic [31:0] key;
        logic        masked;
        int          sel;
        int          cut;
        masked = 1'($urandom_range(1));
        sel = $urandom_range(99);
        if (sel < 55)
        begin
            code = 7'($urandom_range(12));
            len = {57'd0, code};
        end
        else if (sel < 60)
        begin
            code = 7'($urandom_range(125, 100));
            len = {57'd0, code};
        end
        else if (sel < 80)
        begin
            code = 7'(LEN_CODE_16);
            len = 64'($urandom_range(24));
        end
        else
        begin
            code = 7'(LEN_CODE_64);
            len = 64'($urandom_range(24));
        end
        hdr.push_back(8'($urandom));
        hdr.push_back({masked, code});
        if (code == 7'(LEN_CODE_16))
        begin
            for (int i = 1; i >= 0; i--)
            begin
                hdr.push_back(len[8 * i +: 8]);
            end
        end
        else if (code == 7'(LEN_CODE_64))
        begin
            for (int i = 7; i >= 0; i--)
            begin
                hdr.push_back(len[8 * i +: 8]);
            end
        end
        if (masked)
        begin
            key = $urandom;
            for (int i = 3; i >= 0; i--)
            begin
                hdr.push_back(key[8 * i +: 8]);
            end
        end
        if ($urandom_range(99) < 10)
        begin
            cut = $urandom_range(hdr.size() - 2);
            for (int i = 0; i < cut; i++)
            begin
                send_byte(hdr[i], 1'b0);
            end
            send_byte(hdr[cut], 1'b1);
            return;
        end
        for (int i = 0; i < hdr.size(); i++)
        begin
            send_byte(hdr[i], (i == hdr.size() - 1) && ($urandom_range(9) == 0));
        end
        for (longint unsigned n = 0; n < len; n++)
        begin
            send_byte(8'($urandom), $urandom_range(9) == 0);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // End of buffer on the first byte, in the middle of a masking key, on the
    // byte that completes a header, and on payload bytes where it must be
    // ignored.
    task automatic test_buffer_end();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        send_byte(8'h8A, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b1);
        send_byte(8'h0F, 1'b0);
        send_byte(8'h02, 1'b1);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
    endtask

    // Zero-length frames: a plain one, and a masked one whose zero length
    // comes through the 16-bit extended form with all reserved bits set.
    task automatic test_empty_frames();
        send_byte(8'h81, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    task automatic test_random_frames(input int unsigned idle_pct,
                                      input int unsigned stall_pct,
                                      input int unsigned count);
        int unsigned target;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        target = bytes_sent + count;
        while (bytes_sent < target)
        begin
            send_random_frame();
        end
    endtask

    // A 64-bit length of all ones is taken as is. The parser then stays in
    // the payload for good, so this test has to come last.
    task automatic test_huge_length();
        sender_idle_pct = 34;
        receiver_stall_pct = 34;
        send_byte(8'h09, 1'b0);
        send_byte(8'h7F, 1'b0);
        for (int i = 0; i < 8; i++)
        begin
            send_byte(8'hFF, 1'b0);
        end
        for (int i = 0; i < 3; i++)
        begin
            send_byte(8'($urandom), 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = 8'h00;
        byte_ch.end_of_buffer = 1'b0;
        result_ch.ready = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        bytes_sent = 0;
        failures = 0;
        cycle_count = 0;
        clear_frame_state();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Each random phase overshoots its byte count by the tail of its
        // last frame, so the counts are set a little under the total aimed at.
        test_buffer_end();
        test_empty_frames();
        test_random_frames(0, 0, 130);
        test_random_frames(83, 0, 130);
        test_random_frames(0, 83, 130);
        test_random_frames(34, 34, 130);
        test_huge_length();

        // The last beat was taken at this edge; stop offering bytes, let
        // every owed result drain, then give the queue and output register
        // some slack to show any stray beat.
        byte_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (failures == 0 && expected_results.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
